>>> sv/cwu_pkg.sv
// ----------------------------------------------------------------------------
// cwu_pkg: shared types and constants of the congestion window unit
// Operation codes, register indexes, ack table codes, reset values and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cwu_pkg;

   // Event kinds carried on the request side.
   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_INIT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_FIRST_SEQUENCE = 2'd1;
   localparam logic [1:0] CSR_DUP_LIMIT      = 2'd2;

   // Ack table entry codes: the top code marks an unsent segment.
   localparam logic [2:0] CODE_UNSENT = 3'd7;
   localparam logic [2:0] COUNT_MAX   = 3'd6;

   // The ack number the receiver sends when it has everything.
   localparam logic [15:0] ACK_FINISH = 16'd1;

   // Register values after reset.
   localparam logic [7:0]  RST_THRESHOLD = 8'd16;
   localparam logic [15:0] RST_FIRST_SEQ = 16'd1000;
   localparam logic [1:0]  RST_DUP_LIMIT = 2'd3;

   // Result beat width: 36 bits of fields padded to whole bytes.
   localparam int RSP_W = 40;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_SLOT   = 9'b000000100,
      S_READ   = 9'b000001000,
      S_DECIDE = 9'b000010000,
      S_SLOT2  = 9'b000100000,
      S_WRITE2 = 9'b001000000,
      S_STEP   = 9'b010000000,
      S_EMIT   = 9'b100000000
   } cwu_state_type;

endpackage

`default_nettype wire

>>> sv/tahoe_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// tahoe_congestion_window_unit: Tahoe congestion window engine
// Grants sequence numbers, counts acks per sequence in a table, grows the
// window in slow start or avoidance, and collapses it on loss.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  req_*     in         tuser: operation; tdata: ack_number
//  rsp_*     out        tdata: send_now .. finished, one beat per request
//  csr_*     in         write enable, register index, write data
//
// One request beat is handled at a time by a small sequencer. The ack table
// slot, the sequence offset modulo TABLE_DEPTH, comes from a reciprocal
// multiply that is registered at the accepting edge and finished in S_SLOT.
// A single restoring divider, one quotient bit per cycle, forms the
// avoidance step, one over the whole window. From S_IDLE, a send opportunity
// or a slow start ack passes S_SLOT, S_READ and S_DECIDE to S_EMIT; an ack
// in avoidance adds S_STEP, a fast retransmit adds S_SLOT2 and S_WRITE2, a
// timeout passes S_SLOT and S_WRITE2, and an ignored event goes straight to
// S_EMIT. After reset, and after every write of first_sequence, the ack
// table is swept entry by entry to the unsent code; no request is taken
// then, while configuration writes are. A result waiting on rsp_tready does
// not block the next request, which can be taken in the cycle its
// predecessor's result appears; the sequencer waits in its last step only
// when a new result is ready while the old one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module tahoe_congestion_window_unit
   import cwu_pkg::*;
#(
   parameter int TABLE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Request channel.
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [15:0]      req_tdata,   // [15:0] ack_number
   input  wire logic [1:0]       req_tuser,   // [1:0] operation
   // Result channel.
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [0] send_now, [16:1] send_sequence, [17] retransmit, [25:18] window_whole,
   // [33:26] threshold_whole, [34] in_avoidance, [35] finished, [39:36] zero
   output logic [RSP_W-1:0]      rsp_tdata,
   // Configuration port.
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   // Window and threshold are unsigned 8.FRACTION_BITS fixed point.
   localparam int WIN_W  = 8 + FRACTION_BITS;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   // The dividend is 1.0 and the divisor an 8-bit whole window.
   localparam int DVD_W  = FRACTION_BITS + 1;
   localparam int DVS_W  = 8;
   localparam int CNT_W  = $clog2(DVD_W + 1);

   // Table slot: the quotient of offset and depth from a rounded-up
   // reciprocal, exact for every 16-bit offset.
   localparam int     SLOT_SH    = 16 + ADDR_W;
   localparam longint SLOT_RECIP = ((longint'(1) << SLOT_SH) + longint'(TABLE_DEPTH) - 1)
                                   / longint'(TABLE_DEPTH);
   localparam logic [17:0] RECIP_C = 18'(SLOT_RECIP);
   localparam logic [16:0] DEPTH_C = 17'(TABLE_DEPTH);

   localparam logic [WIN_W-1:0]  ONE_FIXED = WIN_W'(1) << FRACTION_BITS;
   localparam logic [DVD_W-1:0]  ONE_DVD   = DVD_W'(1) << FRACTION_BITS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(DVD_W);

   function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
      logic [WIN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WIN_W] ? {WIN_W{1'b1}} : sum[WIN_W-1:0];
   endfunction

   function automatic logic [15:0] slot_quotient(input logic [15:0] off);
      logic [33:0] prod;
      prod = {18'b0, off} * {16'b0, RECIP_C};
      return 16'(prod >> SLOT_SH);
   endfunction

   // Sequencer and architectural state.
   cwu_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [15:0]       first_seq_ff, first_seq_in;
   logic [1:0]        dup_limit_ff, dup_limit_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [WIN_W-1:0]  thresh_ff, thresh_in;
   logic              avoid_ff, avoid_in;
   logic [15:0]       next_seq_ff, next_seq_in;
   logic [15:0]       left_ff, left_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   logic [1:0]        op_ff, op_in;
   logic [15:0]       ack_ff, ack_in;
   logic              grant_ff, grant_in;
   logic [15:0]       grant_seq_ff, grant_seq_in;
   logic              lost_ff, lost_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [15:0]       slot_off_ff, slot_off_in;
   logic [15:0]       slot_quo_ff, slot_quo_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // Restoring divider.
   logic [DVS_W-1:0]  div_rem_ff, div_rem_in;
   logic [DVD_W-1:0]  div_quo_ff, div_quo_in;
   logic [DVS_W-1:0]  div_dvs_ff, div_dvs_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              div_start;
   logic [DVD_W-1:0]  div_dvd;
   logic [DVS_W-1:0]  div_dvs;
   logic              div_done;
   logic [DVS_W:0]    div_shift;
   logic [DVS_W:0]    div_diff;

   // Ack table.
   logic [2:0]        ack_mem [TABLE_DEPTH];
   logic [2:0]        rd_code_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [2:0]        mem_wdata;

   // Helpers.
   logic [7:0]        whole;
   logic [7:0]        whole_div;
   logic [15:0]       distance;
   logic              inside_window;
   logic [2:0]        count_new;
   logic [WIN_W-1:0]  grow_slow;
   logic [WIN_W-1:0]  grow_avoid;
   logic [15:0]       off_next;
   logic [15:0]       off_acked;
   logic [15:0]       off_ack;
   logic [32:0]       slot_back;
   logic [15:0]       slot_rem;

   assign whole     = window_ff[WIN_W-1 -: 8];
   assign whole_div = (whole == 8'd0) ? 8'd1 : whole;
   assign distance  = next_seq_ff - left_ff;
   // The distance is signed: a sequence behind the left bound is inside.
   assign inside_window = $signed({distance[15], distance}) < $signed({9'b0, whole});
   assign grow_slow  = sat_add(window_ff, ONE_FIXED);
   assign grow_avoid = sat_add(window_ff, WIN_W'(div_quo_ff[FRACTION_BITS:0]));
   assign off_next  = next_seq_ff - first_seq_ff;
   assign off_acked = req_tdata - ACK_FINISH - first_seq_ff;
   assign off_ack   = ack_ff - first_seq_ff;
   // The remainder is below the depth, so its low bits are the slot.
   assign slot_back = {17'b0, slot_quo_ff} * {16'b0, DEPTH_C};
   assign slot_rem  = slot_off_ff - slot_back[15:0];

   // An unsent entry counts as the first ack; counts saturate.
   always_comb begin
      if (rd_code_ff == CODE_UNSENT) begin
         count_new = 3'd0;
      end else if (rd_code_ff < COUNT_MAX) begin
         count_new = rd_code_ff + 3'd1;
      end else begin
         count_new = COUNT_MAX;
      end
   end

   assign div_done  = (div_cnt_ff == '0);
   assign div_shift = {div_rem_ff, div_quo_ff[DVD_W-1]};
   assign div_diff  = div_shift - {1'b0, div_dvs_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      first_seq_in = first_seq_ff;
      dup_limit_in = dup_limit_ff;
      window_in    = window_ff;
      thresh_in    = thresh_ff;
      avoid_in     = avoid_ff;
      next_seq_in  = next_seq_ff;
      left_in      = left_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      ack_in       = ack_ff;
      grant_in     = grant_ff;
      grant_seq_in = grant_seq_ff;
      lost_in      = lost_ff;
      slot_in      = slot_ff;
      slot_off_in  = slot_off_ff;
      slot_quo_in  = slot_quo_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = CODE_UNSENT;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvs      = '0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               ack_in   = req_tdata;
               grant_in = 1'b0;
               lost_in  = 1'b0;
               state_in = S_EMIT;
               if (!done_ff) begin
                  case (req_tuser)
                     OP_SEND, OP_TIMEOUT: begin
                        slot_off_in = off_next;
                        slot_quo_in = slot_quotient(off_next);
                        state_in    = S_SLOT;
                     end
                     OP_ACK: begin
                        left_in = next_seq_ff;
                        if (req_tdata == ACK_FINISH) begin
                           done_in = 1'b1;
                        end else begin
                           slot_off_in = off_acked;
                           slot_quo_in = slot_quotient(off_acked);
                           state_in    = S_SLOT;
                        end
                     end
                     default: begin
                        state_in = S_EMIT;
                     end
                  endcase
               end
            end
         end
         S_SLOT: begin
            slot_in  = slot_rem[ADDR_W-1:0];
            state_in = (op_ff == OP_TIMEOUT) ? S_WRITE2 : S_READ;
         end
         S_READ: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_EMIT;
            if (op_ff == OP_SEND) begin
               if (rd_code_ff == CODE_UNSENT && inside_window) begin
                  grant_in     = 1'b1;
                  grant_seq_in = next_seq_ff;
                  mem_we       = 1'b1;
                  mem_wdata    = 3'd0;
                  next_seq_in  = next_seq_ff + 16'd1;
               end
            end else if (count_new < {1'b0, dup_limit_ff}) begin
               mem_we    = 1'b1;
               mem_wdata = count_new;
               if (!avoid_ff) begin
                  window_in = grow_slow;
                  if (grow_slow >= thresh_ff) begin
                     avoid_in = 1'b1;
                  end
               end else begin
                  div_start = 1'b1;
                  div_dvd   = ONE_DVD;
                  div_dvs   = DVS_W'(whole_div);
                  state_in  = S_STEP;
               end
            end else begin
               // Fast retransmit: resend from the acked number.
               mem_we      = 1'b1;
               mem_wdata   = CODE_UNSENT;
               next_seq_in = ack_ff;
               lost_in     = 1'b1;
               slot_off_in = off_ack;
               slot_quo_in = slot_quotient(off_ack);
               state_in    = S_SLOT2;
            end
         end
         S_SLOT2: begin
            slot_in  = slot_rem[ADDR_W-1:0];
            state_in = S_WRITE2;
         end
         S_WRITE2: begin
            mem_we    = 1'b1;
            mem_wdata = CODE_UNSENT;
            thresh_in = window_ff >> 1;
            window_in = ONE_FIXED;
            avoid_in  = 1'b0;
            lost_in   = 1'b1;
            state_in  = S_EMIT;
         end
         S_STEP: begin
            if (div_done) begin
               window_in = grow_avoid;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, done_ff, avoid_ff, thresh_ff[WIN_W-1 -: 8], whole,
                               lost_ff, (grant_ff ? grant_seq_ff : next_seq_ff), grant_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Writes must arrive only while idle or during the table sweep; the block does not enforce it.
      if (csr_wen) begin
         case (csr_index)
            CSR_INIT_THRESHOLD: begin
               thresh_in = WIN_W'(csr_wdata[7:0]) << FRACTION_BITS;
            end
            CSR_FIRST_SEQUENCE: begin
               first_seq_in = csr_wdata;
               next_seq_in  = csr_wdata;
               left_in      = csr_wdata;
               clr_cnt_in   = '0;
               state_in     = S_CLEAR;
            end
            CSR_DUP_LIMIT: begin
               dup_limit_in = csr_wdata[1:0];
            end
            default: begin
               dup_limit_in = dup_limit_ff;
            end
         endcase
      end

      // Restoring divider: one quotient bit per cycle.
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_dvs_in = div_dvs_ff;
      div_cnt_in = div_cnt_ff;
      if (div_start) begin
         div_rem_in = '0;
         div_quo_in = div_dvd;
         div_dvs_in = div_dvs;
         div_cnt_in = DIV_STEPS;
      end else if (!div_done) begin
         div_cnt_in = div_cnt_ff - 1'b1;
         if (!div_diff[DVS_W]) begin
            div_rem_in = div_diff[DVS_W-1:0];
            div_quo_in = {div_quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_shift[DVS_W-1:0];
            div_quo_in = {div_quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         first_seq_ff <= RST_FIRST_SEQ;
         dup_limit_ff <= RST_DUP_LIMIT;
         window_ff    <= ONE_FIXED;
         thresh_ff    <= WIN_W'(RST_THRESHOLD) << FRACTION_BITS;
         avoid_ff     <= 1'b0;
         next_seq_ff  <= RST_FIRST_SEQ;
         left_ff      <= RST_FIRST_SEQ;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         first_seq_ff <= first_seq_in;
         dup_limit_ff <= dup_limit_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         avoid_ff     <= avoid_in;
         next_seq_ff  <= next_seq_in;
         left_ff      <= left_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ack_ff       <= ack_in;
      grant_ff     <= grant_in;
      grant_seq_ff <= grant_seq_in;
      lost_ff      <= lost_in;
      slot_ff      <= slot_in;
      slot_off_ff  <= slot_off_in;
      slot_quo_ff  <= slot_quo_in;
      rsp_data_ff  <= rsp_data_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_dvs_ff   <= div_dvs_in;
   end

   // Ack table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ack_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_READ) begin
         rd_code_ff <= ack_mem[slot_ff];
      end
   end

endmodule

`default_nettype wire

>>> dv/tahoe_window_checker.sv
// ----------------------------------------------------------------------------
// tahoe_window_checker: result predictor and comparator for the window unit
// Watches the request, result and register channels, keeps its own copy of
// the Tahoe window state, and compares every result beat field by field.
// ----------------------------------------------------------------------------

module tahoe_window_checker
   import cwu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [15:0]      req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output int                    error_count,
   output int                    pending_count,
   output int                    beat_count,
   output int                    grant_count,
   output int                    loss_count
);

   localparam int          TABLE_DEPTH = 1024;
   localparam logic [15:0] ONE_FX      = 16'h0100;

   typedef struct {
      logic        send_now;
      logic [15:0] send_sequence;
      logic        retransmit;
      logic [7:0]  window_whole;
      logic [7:0]  threshold_whole;
      logic        in_avoidance;
      logic        finished;
   } window_report_type;

   window_report_type due_reports[$];

   // Register copies.
   logic [7:0]  init_thr;
   logic [15:0] first_seq;
   logic [1:0]  dup_limit;

   // Window state, 8.8 fixed point for the window and the threshold.
   logic [15:0] win_fx;
   logic [15:0] thr_fx;
   logic        avoid;
   logic [15:0] next_seq;
   logic [15:0] left_bnd;
   logic        done;
   logic [2:0]  ack_tbl [TABLE_DEPTH];

   function automatic int slot_of(input logic [15:0] seq);
      logic [15:0] off;
      off = seq - first_seq;
      return int'(off) % TABLE_DEPTH;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   task automatic mark_unsent();
      for (int i = 0; i < TABLE_DEPTH; i++) ack_tbl[i] = CODE_UNSENT;
   endtask

   task automatic halve_window();
      thr_fx = win_fx >> 1;
      win_fx = ONE_FX;
      avoid  = 1'b0;
   endtask

   task automatic restore_defaults();
      init_thr  = RST_THRESHOLD;
      first_seq = RST_FIRST_SEQ;
      dup_limit = RST_DUP_LIMIT;
      win_fx    = ONE_FX;
      thr_fx    = {init_thr, 8'h00};
      avoid     = 1'b0;
      next_seq  = first_seq;
      left_bnd  = first_seq;
      done      = 1'b0;
      mark_unsent();
   endtask

   task automatic apply_register(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
         CSR_INIT_THRESHOLD: begin
            init_thr = data[7:0];
            thr_fx   = {init_thr, 8'h00};
         end
         CSR_FIRST_SEQUENCE: begin
            first_seq = data;
            next_seq  = data;
            left_bnd  = data;
            mark_unsent();
         end
         CSR_DUP_LIMIT: begin
            dup_limit = data[1:0];
         end
         default: ;
      endcase
   endtask

   // Applies one event to the model state and queues the result it causes.
   task automatic advance_window(input logic [1:0] op, input logic [15:0] ackn);
      window_report_type rpt;
      int                slot;
      int                span;
      int                whole;
      logic [15:0]       diff;
      logic [15:0]       acked;
      logic [2:0]        cnt;
      rpt.send_now      = 1'b0;
      rpt.retransmit    = 1'b0;
      rpt.send_sequence = 16'h0000;
      if (!done) begin
         case (op)
            OP_SEND: begin
               slot  = slot_of(next_seq);
               diff  = next_seq - left_bnd;
               span  = $signed(diff);
               whole = win_fx[15:8];
               if (ack_tbl[slot] == CODE_UNSENT && span < whole) begin
                  rpt.send_now      = 1'b1;
                  rpt.send_sequence = next_seq;
                  ack_tbl[slot]     = 3'd0;
                  next_seq          = next_seq + 16'd1;
               end
            end
            OP_ACK: begin
               left_bnd = next_seq;
               if (ackn == ACK_FINISH) begin
                  done = 1'b1;
               end else begin
                  acked = ackn - 16'd1;
                  slot  = slot_of(acked);
                  cnt   = ack_tbl[slot];
                  if (cnt == CODE_UNSENT) cnt = 3'd0;
                  else if (cnt < COUNT_MAX) cnt = cnt + 3'd1;
                  ack_tbl[slot] = cnt;
                  if (cnt < {1'b0, dup_limit}) begin
                     if (!avoid) begin
                        win_fx = sat_add(win_fx, ONE_FX);
                        if (win_fx >= thr_fx) avoid = 1'b1;
                     end else begin
                        whole = win_fx[15:8];
                        if (whole == 0) whole = 1;
                        win_fx = sat_add(win_fx, 16'(int'(ONE_FX) / whole));
                     end
                  end else begin
                     // Fast retransmit: rewind to the acked point and collapse.
                     rpt.retransmit         = 1'b1;
                     next_seq               = ackn;
                     ack_tbl[slot_of(ackn)] = CODE_UNSENT;
                     ack_tbl[slot]          = CODE_UNSENT;
                     halve_window();
                  end
               end
            end
            OP_TIMEOUT: begin
               rpt.retransmit             = 1'b1;
               ack_tbl[slot_of(next_seq)] = CODE_UNSENT;
               halve_window();
            end
            default: ;
         endcase
      end
      if (!rpt.send_now) rpt.send_sequence = next_seq;
      rpt.window_whole    = win_fx[15:8];
      rpt.threshold_whole = thr_fx[15:8];
      rpt.in_avoidance    = avoid;
      rpt.finished        = done;
      if (rpt.send_now) grant_count++;
      if (rpt.retransmit) loss_count++;
      due_reports.push_back(rpt);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      window_report_type want;
      if (reset) begin
         restore_defaults();
         due_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beat_count++;
            if (due_reports.size() == 0) begin
               $error("result beat 0x%0h arrived with no event waiting", rsp_tdata);
               error_count++;
            end else begin
               want = due_reports.pop_front();
               check_field("send_now", 16'(want.send_now), 16'(rsp_tdata[0]));
               check_field("send_sequence", want.send_sequence, rsp_tdata[16:1]);
               check_field("retransmit", 16'(want.retransmit), 16'(rsp_tdata[17]));
               check_field("window_whole", 16'(want.window_whole), 16'(rsp_tdata[25:18]));
               check_field("threshold_whole", 16'(want.threshold_whole),
                           16'(rsp_tdata[33:26]));
               check_field("in_avoidance", 16'(want.in_avoidance), 16'(rsp_tdata[34]));
               check_field("finished", 16'(want.finished), 16'(rsp_tdata[35]));
               check_field("padding", 16'h0000, 16'(rsp_tdata[RSP_W-1:36]));
            end
         end
         if (csr_wen) apply_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) advance_window(req_tuser, req_tdata);
      end
      pending_count = due_reports.size();
   end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the Tahoe congestion window unit
// Drives send, ack, timeout and reserved events through several register
// settings with random stalls on both channels; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_top
   import cwu_pkg::*;
();

   // Codes the package leaves unnamed: the fourth operation and register index.
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;

   localparam int IDLE_PCT       = 35;
   localparam int PHASE_EVENTS   = 80;
   localparam int PHASE_COUNT    = 5;
   localparam int DRAIN_CYCLES   = 64;
   // The longest event and the table sweep after a first_sequence write both
   // end far below this limit, so it leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [15:0]      req_tdata;   // [15:0] ack_number
   logic [1:0]       req_tuser;   // [1:0] operation
   logic             rsp_tvalid;
   logic             rsp_tready;
   // [0] send_now, [16:1] send_sequence, [17] retransmit, [25:18] window_whole,
   // [33:26] threshold_whole, [34] in_avoidance, [35] finished, [39:36] zero
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wen;
   logic [1:0]       csr_index;
   logic [15:0]      csr_wdata;

   int error_count;
   int pending_count;
   int beat_count;
   int grant_count;
   int loss_count;

   int          stall_cycles;
   logic        calm;        // when set, neither side idles
   logic [15:0] seq_hint;    // latest sequence reported by the block
   logic [15:0] burst_ack;   // ack number being repeated as duplicates
   int          burst_left;

   tahoe_congestion_window_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tahoe_window_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .beat_count    (beat_count),
      .grant_count   (grant_count),
      .loss_count    (loss_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver drops rsp_tready at random except during the calm stretch.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Each result tells where the block's next sequence stands; the ack
   // generator aims just behind it so that acks land on granted entries.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) seq_hint <= rsp_tdata[16:1];
   end

   // Watchdog: a long run of cycles with no beat on either channel means the
   // block has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d cycles with no beat", stall_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Presents one event and returns at the falling edge after its beat was
   // taken. tvalid stays high into the next call, so back-to-back events
   // never drop it, and the sender idles at random before each event.
   task automatic push_event(input logic [1:0] op, input logic [15:0] ackn);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ackn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write, taken at the next rising edge.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen   <= 1'b0;
      if (idx == CSR_FIRST_SEQUENCE) seq_hint = data;
      @(negedge clock);
   endtask

   // Stops the sender until every predicted result has been returned.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   // Mostly well-formed traffic: sends, acks just behind the current
   // sequence, and bursts of repeated acks that drive the duplicate counter
   // to its limit. The rest is far-off acks, timeouts and the reserved code.
   // The finishing ack number is kept back for the very end of the run.
   task automatic next_random_event(output logic [1:0] op, output logic [15:0] ackn);
      int pick;
      pick = $urandom_range(0, 99);
      ackn = 16'($urandom);
      if (burst_left > 0) begin
         op   = OP_ACK;
         ackn = burst_ack;
         burst_left--;
      end else if (pick < 45) begin
         op = OP_SEND;
      end else if (pick < 85) begin
         op   = OP_ACK;
         ackn = seq_hint + 16'd1 - 16'($urandom_range(0, 6));
         if ($urandom_range(0, 99) < 20) begin
            burst_ack  = ackn;
            burst_left = $urandom_range(1, 3);
         end
      end else if (pick < 91) begin
         op = OP_ACK;
      end else if (pick < 97) begin
         op = OP_TIMEOUT;
      end else begin
         op = OP_RESERVED;
      end
      if (op == OP_ACK && ackn == ACK_FINISH) ackn = ACK_FINISH + 16'd1;
      if (op == OP_ACK && burst_left > 0 && burst_ack == ACK_FINISH) burst_ack = ackn;
   endtask

   initial begin
      logic [1:0]  op;
      logic [15:0] ackn;
      logic [7:0]  thr_set   [PHASE_COUNT];
      logic [15:0] first_set [PHASE_COUNT];
      logic [1:0]  dup_set   [PHASE_COUNT];

      // Every input is known from time zero; reset is held high at the start.
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 16'h0000;
      req_tuser  = OP_SEND;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = CSR_INIT_THRESHOLD;
      csr_wdata  = 16'h0000;
      calm       = 1'b0;
      seq_hint   = RST_FIRST_SEQ;
      burst_ack  = 16'h0000;
      burst_left = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed events on the reset settings. The block is still sweeping
      // its table, so the first beat waits on req_tready. A grant, a send
      // blocked by the one-segment window, growth on an ack, then duplicate
      // acks up to the limit for fast retransmit, a timeout, the reserved
      // code, acks that wrap below zero, and all-ones and alternating data.
      push_event(OP_SEND,     16'h0000);
      push_event(OP_SEND,     16'hFFFF);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd1);
      push_event(OP_SEND,     16'h0000);
      push_event(OP_SEND,     16'h0000);
      push_event(OP_SEND,     16'h0000);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd1);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd1);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd2);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd2);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd2);
      push_event(OP_ACK,      RST_FIRST_SEQ + 16'd2);
      push_event(OP_TIMEOUT,  16'h0000);
      push_event(OP_RESERVED, 16'hFFFF);
      push_event(OP_ACK,      16'h0000);
      push_event(OP_ACK,      16'hFFFF);
      push_event(OP_ACK,      16'h5555);
      push_event(OP_ACK,      16'hAAAA);
      push_event(OP_SEND,     16'hAAAA);
      push_event(OP_SEND,     16'h5555);
      push_event(OP_TIMEOUT,  16'hFFFF);
      push_event(OP_SEND,     16'h0000);
      drain_results();

      // Register settings per phase: both ends of the threshold, sequence
      // bases at the top of the space and across the wrap, and every
      // duplicate limit the field can hold, the two small ones included.
      thr_set[0] = 8'd255;  first_set[0] = 16'hFFFF; dup_set[0] = 2'd2;
      thr_set[1] = 8'd1;    first_set[1] = 16'h0000; dup_set[1] = 2'd3;
      thr_set[2] = 8'd0;    first_set[2] = 16'hFFF8; dup_set[2] = 2'd0;
      thr_set[3] = 8'($urandom_range(1, 255));
      first_set[3] = 16'($urandom);
      dup_set[3] = 2'd1;
      thr_set[4] = 8'($urandom_range(1, 255));
      first_set[4] = 16'($urandom);
      dup_set[4] = 2'($urandom_range(2, 3));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // Upper data bits beyond a register's width are random noise.
         write_reg(CSR_INIT_THRESHOLD, {8'($urandom), thr_set[p]});
         write_reg(CSR_DUP_LIMIT, {14'($urandom), dup_set[p]});
         // The last phase keeps the table and window left by the one before.
         if (p < PHASE_COUNT - 1) write_reg(CSR_FIRST_SEQUENCE, first_set[p]);
         else write_reg(CSR_UNUSED, 16'($urandom));
         burst_left = 0;
         calm       = (p == 1);
         for (int k = 0; k < PHASE_EVENTS; k++) begin
            // In the first phase the sender once holds off mid-phase until the block is empty.
            if (p == 0 && k == PHASE_EVENTS / 2) drain_results();
            next_random_event(op, ackn);
            push_event(op, ackn);
         end
         drain_results();
      end
      calm = 1'b0;

      // The finishing ack freezes the block; the events after it must only
      // echo the frozen state.
      push_event(OP_ACK,     ACK_FINISH);
      push_event(OP_SEND,    16'h0000);
      push_event(OP_ACK,     seq_hint);
      push_event(OP_TIMEOUT, 16'hFFFF);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result beats: directed events plus %0d random phases,",
               beat_count, PHASE_COUNT);
      $display("with %0d grants, %0d loss events and the finishing ack.",
               grant_count, loss_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/cwu_pkg.sv
sv/tahoe_congestion_window_unit.sv
dv/tahoe_window_checker.sv
dv/tb_top.sv
